/* hdl/ats_pkg.sv */
// ats_pkg: shared types and constants for the alarm tone sequencer
// holds register indexes, item kinds, the register set and result structs
// no dependencies
package ats_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // settle time of the stop button in ticks, and the drive level of a tone
   localparam logic [15:0] DEBOUNCE_MS = 16'd50;
   localparam logic [7:0]  DUTY        = 8'd128;

   localparam logic [15:0] RST_BASE_HZ       = 16'd1000;
   localparam logic [15:0] RST_TOP_HZ        = 16'd3000;
   localparam logic [15:0] RST_SWEEP_STEP_HZ = 16'd100;
   localparam logic [15:0] RST_BEEP_HZ       = 16'd2500;
   localparam logic [15:0] RST_SWEEP_STEP_MS = 16'd20;
   localparam logic [15:0] RST_BEEP_ON_MS    = 16'd200;
   localparam logic [15:0] RST_BEEP_OFF_MS   = 16'd200;
   localparam logic [5:0]  RST_BEEPS         = 6'd3;

   localparam logic [6:0] PHASE_UP   = 7'd0;
   localparam logic [6:0] PHASE_DOWN = 7'd1;
   localparam logic [6:0] PHASE_BEEP = 7'd2;

   typedef enum logic [2:0] {
      CSR_BASE_HZ       = 3'd0,
      CSR_TOP_HZ        = 3'd1,
      CSR_SWEEP_STEP_HZ = 3'd2,
      CSR_BEEP_HZ       = 3'd3,
      CSR_SWEEP_STEP_MS = 3'd4,
      CSR_BEEP_ON_MS    = 3'd5,
      CSR_BEEP_OFF_MS   = 3'd6,
      CSR_BEEPS         = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] base_hz;
      logic [15:0] top_hz;
      logic [15:0] sweep_step_hz;
      logic [15:0] beep_hz;
      logic [15:0] sweep_step_ms;
      logic [15:0] beep_on_ms;
      logic [15:0] beep_off_ms;
      logic [5:0]  beeps_per_cycle;
   } cfg_type;

   typedef struct packed {
      logic        alarm_active;
      logic [15:0] reported_hz;
      logic [15:0] drive_hz;
      logic        drive_on;
      logic        button_stopped;
   } result_type;

endpackage

/* hdl/ats_csr.sv */
// ats_csr: configuration register file behind the apb-style port
// depends on ats_pkg for the register indexes and the register set struct
module ats_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ats_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ats_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ats_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output ats_pkg::cfg_type                 cfg
);
   import ats_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx   = csr_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_BASE_HZ:       cfg_in.base_hz         = csr_pwdata[15:0];
            CSR_TOP_HZ:        cfg_in.top_hz          = csr_pwdata[15:0];
            CSR_SWEEP_STEP_HZ: cfg_in.sweep_step_hz   = csr_pwdata[15:0];
            CSR_BEEP_HZ:       cfg_in.beep_hz         = csr_pwdata[15:0];
            CSR_SWEEP_STEP_MS: cfg_in.sweep_step_ms   = csr_pwdata[15:0];
            CSR_BEEP_ON_MS:    cfg_in.beep_on_ms      = csr_pwdata[15:0];
            CSR_BEEP_OFF_MS:   cfg_in.beep_off_ms     = csr_pwdata[15:0];
            CSR_BEEPS:         cfg_in.beeps_per_cycle = csr_pwdata[5:0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         CSR_BASE_HZ:       csr_prdata[15:0] = cfg_ff.base_hz;
         CSR_TOP_HZ:        csr_prdata[15:0] = cfg_ff.top_hz;
         CSR_SWEEP_STEP_HZ: csr_prdata[15:0] = cfg_ff.sweep_step_hz;
         CSR_BEEP_HZ:       csr_prdata[15:0] = cfg_ff.beep_hz;
         CSR_SWEEP_STEP_MS: csr_prdata[15:0] = cfg_ff.sweep_step_ms;
         CSR_BEEP_ON_MS:    csr_prdata[15:0] = cfg_ff.beep_on_ms;
         CSR_BEEP_OFF_MS:   csr_prdata[15:0] = cfg_ff.beep_off_ms;
         CSR_BEEPS:         csr_prdata[5:0]  = cfg_ff.beeps_per_cycle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_hz         <= RST_BASE_HZ;
         cfg_ff.top_hz          <= RST_TOP_HZ;
         cfg_ff.sweep_step_hz   <= RST_SWEEP_STEP_HZ;
         cfg_ff.beep_hz         <= RST_BEEP_HZ;
         cfg_ff.sweep_step_ms   <= RST_SWEEP_STEP_MS;
         cfg_ff.beep_on_ms      <= RST_BEEP_ON_MS;
         cfg_ff.beep_off_ms     <= RST_BEEP_OFF_MS;
         cfg_ff.beeps_per_cycle <= RST_BEEPS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/ats_seq.sv */
// ats_seq: sequencer state, button debounce and next-state logic for one item
// depends on ats_pkg for item kinds, phase codes, the register set and result
module ats_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [1:0]           kind,
   input  logic                 button_level,
   input  ats_pkg::cfg_type     cfg,
   output ats_pkg::result_type  result
);
   import ats_pkg::*;

   logic        running_ff,        running_in;
   logic [6:0]  phase_ff,          phase_in;
   logic [15:0] seq_hz_ff,         seq_hz_in;
   logic [5:0]  beeps_done_ff,     beeps_done_in;
   logic [15:0] step_elapsed_ff,   step_elapsed_in;
   logic [15:0] settle_elapsed_ff, settle_elapsed_in;
   logic        last_raw_ff,       last_raw_in;
   logic        stable_level_ff,   stable_level_in;
   logic [15:0] tone_hz_ff,        tone_hz_in;
   logic        playing_ff,        playing_in;

   logic [15:0] step_inc;
   logic [15:0] settle_inc;
   logic [15:0] settle_chk;
   logic [15:0] interval;
   logic [16:0] up_sum;
   logic [17:0] down_diff;
   logic        down_end;
   logic [5:0]  beeps_inc;
   logic        settled_low;
   logic        settled_new;
   logic        stopped;

   assign step_inc   = (step_elapsed_ff == 16'hFFFF) ? step_elapsed_ff : step_elapsed_ff + 16'd1;
   assign settle_inc = (settle_elapsed_ff == 16'hFFFF) ? settle_elapsed_ff
                                                        : settle_elapsed_ff + 16'd1;
   // a change of raw level restarts the settle time
   assign settle_chk  = (button_level != last_raw_ff) ? 16'd0 : settle_inc;
   assign settled_new = (settle_chk > DEBOUNCE_MS) && (button_level != stable_level_ff);
   assign settled_low = settled_new && !button_level;

   always_comb begin
      if (phase_ff == PHASE_UP || phase_ff == PHASE_DOWN) begin
         interval = cfg.sweep_step_ms;
      end else if (!phase_ff[0]) begin
         interval = cfg.beep_on_ms;
      end else begin
         interval = cfg.beep_off_ms;
      end
   end

   assign up_sum    = {1'b0, seq_hz_ff} + {1'b0, cfg.sweep_step_hz};
   assign down_diff = {2'b00, seq_hz_ff} - {2'b00, cfg.sweep_step_hz};
   assign down_end  = $signed(down_diff) <= $signed({2'b00, cfg.base_hz});
   assign beeps_inc = beeps_done_ff + 6'd1;

   always_comb begin
      running_in        = running_ff;
      phase_in          = phase_ff;
      seq_hz_in         = seq_hz_ff;
      beeps_done_in     = beeps_done_ff;
      step_elapsed_in   = step_elapsed_ff;
      settle_elapsed_in = settle_elapsed_ff;
      last_raw_in       = last_raw_ff;
      stable_level_in   = stable_level_ff;
      tone_hz_in        = tone_hz_ff;
      playing_in        = playing_ff;
      stopped           = 1'b0;
      unique case (kind)
         KIND_TICK: begin
            step_elapsed_in   = step_inc;
            settle_elapsed_in = settle_inc;
            if (running_ff) begin
               settle_elapsed_in = settle_chk;
               last_raw_in       = button_level;
               if (settled_new) begin
                  stable_level_in = button_level;
               end
               if (settled_low) begin
                  stopped       = 1'b1;
                  running_in    = 1'b0;
                  phase_in      = PHASE_UP;
                  seq_hz_in     = '0;
                  beeps_done_in = '0;
                  tone_hz_in    = '0;
                  playing_in    = 1'b0;
               end else if (step_inc >= interval) begin
                  step_elapsed_in = '0;
                  priority if (phase_ff == PHASE_UP) begin
                     if (up_sum >= {1'b0, cfg.top_hz}) begin
                        seq_hz_in = cfg.top_hz;
                        phase_in  = PHASE_DOWN;
                     end else begin
                        seq_hz_in = up_sum[15:0];
                     end
                     tone_hz_in = seq_hz_in;
                     playing_in = 1'b1;
                  end else if (phase_ff == PHASE_DOWN) begin
                     if (down_end) begin
                        seq_hz_in     = cfg.base_hz;
                        phase_in      = PHASE_BEEP;
                        beeps_done_in = '0;
                     end else begin
                        seq_hz_in = down_diff[15:0];
                     end
                     tone_hz_in = seq_hz_in;
                     playing_in = 1'b1;
                  end else if (!phase_ff[0]) begin
                     seq_hz_in  = cfg.beep_hz;
                     tone_hz_in = cfg.beep_hz;
                     playing_in = 1'b1;
                     phase_in   = phase_ff + 7'd1;
                  end else begin
                     tone_hz_in = '0;
                     playing_in = 1'b0;
                     // last beep done: back to a silent sweep start
                     if (beeps_inc >= cfg.beeps_per_cycle || beeps_inc == '0) begin
                        phase_in      = PHASE_UP;
                        seq_hz_in     = cfg.base_hz;
                        beeps_done_in = '0;
                     end else begin
                        beeps_done_in = beeps_inc;
                        phase_in      = phase_ff + 7'd1;
                     end
                  end
               end
            end
         end
         KIND_START: begin
            running_in      = 1'b1;
            step_elapsed_in = '0;
            phase_in        = PHASE_UP;
            beeps_done_in   = '0;
            seq_hz_in       = cfg.base_hz;
            tone_hz_in      = cfg.base_hz;
            playing_in      = 1'b1;
         end
         KIND_STOP: begin
            running_in    = 1'b0;
            phase_in      = PHASE_UP;
            seq_hz_in     = '0;
            beeps_done_in = '0;
            tone_hz_in    = '0;
            playing_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff        <= 1'b0;
         phase_ff          <= PHASE_UP;
         seq_hz_ff         <= '0;
         beeps_done_ff     <= '0;
         step_elapsed_ff   <= '0;
         settle_elapsed_ff <= '0;
         last_raw_ff       <= 1'b1;
         stable_level_ff   <= 1'b1;
         tone_hz_ff        <= '0;
         playing_ff        <= 1'b0;
      end else if (step_en) begin
         running_ff        <= running_in;
         phase_ff          <= phase_in;
         seq_hz_ff         <= seq_hz_in;
         beeps_done_ff     <= beeps_done_in;
         step_elapsed_ff   <= step_elapsed_in;
         settle_elapsed_ff <= settle_elapsed_in;
         last_raw_ff       <= last_raw_in;
         stable_level_ff   <= stable_level_in;
         tone_hz_ff        <= tone_hz_in;
         playing_ff        <= playing_in;
      end
   end

   assign result.alarm_active   = running_in;
   assign result.reported_hz    = seq_hz_in;
   assign result.drive_hz       = tone_hz_in;
   assign result.drive_on       = playing_in && (DUTY != 8'd0);
   assign result.button_stopped = stopped;

endmodule

/* hdl/alarm_tone_sequencer.sv */
// alarm_tone_sequencer: top level, item handshake and result register
// depends on ats_pkg, ats_csr and ats_seq
//
//   port group   direction  moves
//   req_*        in         one event item: tick, start or stop
//   rsp_*        out        one status item per event item
//   csr_*        in/out     apb-style access to the eight config registers
//
// state is updated and the result register loaded at the edge that accepts
// an item, so a new item can enter every cycle while req_ready is high
// the result appears on rsp_* in the cycle after acceptance
// req_ready drops only while a result waits in the result register and
// rsp_ready is low; reset is synchronous, with no clearing pass
module alarm_tone_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic                             req_button_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_alarm_active,
   output logic [15:0]                      rsp_reported_hz,
   output logic [15:0]                      rsp_drive_hz,
   output logic                             rsp_drive_on,
   output logic                             rsp_button_stopped,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ats_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ats_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ats_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ats_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign csr_pready = 1'b1;

   ats_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   ats_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .kind         (req_kind),
      .button_level (req_button_level),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alarm_active   = rsp_ff.alarm_active;
   assign rsp_reported_hz    = rsp_ff.reported_hz;
   assign rsp_drive_hz       = rsp_ff.drive_hz;
   assign rsp_drive_on       = rsp_ff.drive_on;
   assign rsp_button_stopped = rsp_ff.button_stopped;

endmodule

/* hdl/ats_checker.sv */
// ats_checker: port-level assertions for the alarm tone sequencer
// depends on ats_pkg; bound to alarm_tone_sequencer at the end of this file
module ats_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_alarm_active,
   input  logic [15:0]                      rsp_reported_hz,
   input  logic [15:0]                      rsp_drive_hz,
   input  logic                             rsp_drive_on,
   input  logic                             rsp_button_stopped
);
   import ats_pkg::*;

   // a stalled item holds its reported and drive frequencies and its active flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reported_hz)
         && $stable(rsp_drive_hz) && $stable(rsp_alarm_active))
      else $error("result item changed while stalled");

   // a waiting result blocks the input side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result register full");

   // stopped alarm reports silence
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alarm_active |-> rsp_reported_hz == 16'd0
         && rsp_drive_hz == 16'd0 && !rsp_drive_on)
      else $error("stopped alarm shows a tone");

   a_button_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_button_stopped |-> !rsp_alarm_active)
      else $error("button stop left the alarm active");

   // start item gives an active, sounding result in the next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_START |=> rsp_valid && rsp_alarm_active
         && rsp_drive_on == (DUTY != 8'd0))
      else $error("start item did not start the alarm");

endmodule

bind alarm_tone_sequencer ats_checker u_ats_checker (.*);

/* bench/alarm_tone_sequencer_test.sv */
// alarm_tone_sequencer_test: self-checking bench for the alarm tone sequencer
// drives event items and apb register writes, predicts every status item and checks it
// depends on ats_pkg and alarm_tone_sequencer
`timescale 1ns / 1ps

module alarm_tone_sequencer_test;
   import ats_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT = 32;

   typedef struct {
      logic [1:0] kind;
      logic       level;
   } event_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_kind;
   logic                  req_button_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_alarm_active;
   logic [15:0]           rsp_reported_hz;
   logic [15:0]           rsp_drive_hz;
   logic                  rsp_drive_on;
   logic                  rsp_button_stopped;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   event_item_type pending_q[$];
   result_type     status_q[$];
   logic           req_taken;
   logic           calm;
   int             faults;
   int             cycle_count;

   // sequencer copy used for prediction
   cfg_type     cfg_now;
   logic        run;
   logic [6:0]  stage;
   logic [15:0] seq_now;
   logic [15:0] tone_now;
   logic [5:0]  beeps;
   logic [15:0] step_cnt;
   logic [15:0] settle_cnt;
   logic        raw_prev;
   logic        level_stable;
   logic        sounding;

   alarm_tone_sequencer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_button_level   (req_button_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_alarm_active   (rsp_alarm_active),
      .rsp_reported_hz    (rsp_reported_hz),
      .rsp_drive_hz       (rsp_drive_hz),
      .rsp_drive_on       (rsp_drive_on),
      .rsp_button_stopped (rsp_button_stopped),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   function automatic void play_tone(input logic [15:0] hz);
      seq_now  = hz;
      tone_now = hz;
      sounding = 1'b1;
   endfunction

   function automatic void mute_tone();
      tone_now = 16'd0;
      sounding = 1'b0;
   endfunction

   function automatic void halt_tone();
      run     = 1'b0;
      stage   = PHASE_UP;
      seq_now = 16'd0;
      beeps   = 6'd0;
      mute_tone();
   endfunction

   function automatic result_type next_status(input logic [1:0] kind, input logic level);
      result_type  r;
      logic [15:0] interval;
      logic [16:0] up;
      int          down;
      logic        by_button;
      by_button = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (step_cnt != 16'hFFFF) step_cnt = step_cnt + 16'd1;
            if (settle_cnt != 16'hFFFF) settle_cnt = settle_cnt + 16'd1;
            if (run) begin
               // debounce only while the alarm runs
               if (level != raw_prev) begin
                  settle_cnt = 16'd0;
                  raw_prev   = level;
               end
               if (settle_cnt > DEBOUNCE_MS && level != level_stable) begin
                  level_stable = level;
                  by_button    = !level;
               end
               if (by_button) begin
                  halt_tone();
               end else begin
                  if (stage < PHASE_BEEP) interval = cfg_now.sweep_step_ms;
                  else interval = stage[0] ? cfg_now.beep_off_ms : cfg_now.beep_on_ms;
                  if (step_cnt >= interval) begin
                     step_cnt = 16'd0;
                     if (stage == PHASE_UP) begin
                        up = {1'b0, seq_now} + {1'b0, cfg_now.sweep_step_hz};
                        if (up >= {1'b0, cfg_now.top_hz}) begin
                           up    = {1'b0, cfg_now.top_hz};
                           stage = PHASE_DOWN;
                        end
                        play_tone(up[15:0]);
                     end else if (stage == PHASE_DOWN) begin
                        down = int'(seq_now) - int'(cfg_now.sweep_step_hz);
                        if (down <= int'(cfg_now.base_hz)) begin
                           play_tone(cfg_now.base_hz);
                           stage = PHASE_BEEP;
                           beeps = 6'd0;
                        end else begin
                           play_tone(down[15:0]);
                        end
                     end else if (!stage[0]) begin
                        play_tone(cfg_now.beep_hz);
                        stage = stage + 7'd1;
                     end else begin
                        mute_tone();
                        beeps = beeps + 6'd1;
                        // a wrapped count also ends the cycle
                        if (beeps >= cfg_now.beeps_per_cycle || beeps == 6'd0) begin
                           stage   = PHASE_UP;
                           seq_now = cfg_now.base_hz;
                           beeps   = 6'd0;
                        end else begin
                           stage = stage + 7'd1;
                        end
                     end
                  end
               end
            end
         end
         KIND_START: begin
            run      = 1'b1;
            step_cnt = 16'd0;
            stage    = PHASE_UP;
            beeps    = 6'd0;
            play_tone(cfg_now.base_hz);
         end
         KIND_STOP: halt_tone();
         default: ;
      endcase
      r.alarm_active   = run;
      r.reported_hz    = seq_now;
      r.drive_hz       = tone_now;
      r.drive_on       = sounding && (DUTY != 8'd0);
      r.button_stopped = by_button;
      return r;
   endfunction

   task automatic add_event(input logic [1:0] kind, input logic level);
      event_item_type e;
      e.kind  = kind;
      e.level = level;
      pending_q.push_back(e);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_BASE_HZ:       cfg_now.base_hz = value;
         CSR_TOP_HZ:        cfg_now.top_hz = value;
         CSR_SWEEP_STEP_HZ: cfg_now.sweep_step_hz = value;
         CSR_BEEP_HZ:       cfg_now.beep_hz = value;
         CSR_SWEEP_STEP_MS: cfg_now.sweep_step_ms = value;
         CSR_BEEP_ON_MS:    cfg_now.beep_on_ms = value;
         CSR_BEEP_OFF_MS:   cfg_now.beep_off_ms = value;
         CSR_BEEPS:         cfg_now.beeps_per_cycle = value[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input cfg_type c);
      csr_write(CSR_BASE_HZ, c.base_hz);
      csr_write(CSR_TOP_HZ, c.top_hz);
      csr_write(CSR_SWEEP_STEP_HZ, c.sweep_step_hz);
      csr_write(CSR_BEEP_HZ, c.beep_hz);
      csr_write(CSR_SWEEP_STEP_MS, c.sweep_step_ms);
      csr_write(CSR_BEEP_ON_MS, c.beep_on_ms);
      csr_write(CSR_BEEP_OFF_MS, c.beep_off_ms);
      csr_write(CSR_BEEPS, {10'd0, c.beeps_per_cycle});
   endtask

   // sender holds off until every status item is back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_q.size() != 0 || req_valid || status_q.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin : driver
      event_item_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            e = pending_q.pop_front();
            req_valid        <= 1'b1;
            req_kind         <= e.kind;
            req_button_level <= e.level;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : sink
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : monitor
      result_type seen;
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            status_q.push_back(next_status(req_kind, req_button_level));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            seen.alarm_active   = rsp_alarm_active;
            seen.reported_hz    = rsp_reported_hz;
            seen.drive_hz       = rsp_drive_hz;
            seen.drive_on       = rsp_drive_on;
            seen.button_stopped = rsp_button_stopped;
            if (status_q.size() == 0) begin
               if (faults < 10) $display("unexpected status item %h", seen);
               faults = faults + 1;
            end else begin
               want = status_q.pop_front();
               if (seen.alarm_active !== want.alarm_active
                   || seen.reported_hz !== want.reported_hz
                   || seen.drive_hz !== want.drive_hz
                   || seen.drive_on !== want.drive_on
                   || seen.button_stopped !== want.button_stopped) begin
                  if (faults < 10)
                     $display({"status mismatch: expected active %0d hz %0d drive %0d on %0d",
                               " button %0d, got active %0d hz %0d drive %0d on %0d button %0d"},
                              want.alarm_active, want.reported_hz, want.drive_hz,
                              want.drive_on, want.button_stopped,
                              seen.alarm_active, seen.reported_hz, seen.drive_hz,
                              seen.drive_on, seen.button_stopped);
                  faults = faults + 1;
               end
            end
         end
      end
   end

   initial begin : stimulus
      cfg_type    c;
      int         press_left;
      int         r;
      logic [1:0] kind;
      logic       level;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_TICK;
      req_button_level = 1'b1;
      rsp_ready        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_taken        = 1'b0;
      calm             = 1'b0;
      faults           = 0;
      cycle_count      = 0;
      press_left       = 0;
      cfg_now.base_hz         = RST_BASE_HZ;
      cfg_now.top_hz          = RST_TOP_HZ;
      cfg_now.sweep_step_hz   = RST_SWEEP_STEP_HZ;
      cfg_now.beep_hz         = RST_BEEP_HZ;
      cfg_now.sweep_step_ms   = RST_SWEEP_STEP_MS;
      cfg_now.beep_on_ms      = RST_BEEP_ON_MS;
      cfg_now.beep_off_ms     = RST_BEEP_OFF_MS;
      cfg_now.beeps_per_cycle = RST_BEEPS;
      step_cnt     = 16'd0;
      settle_cnt   = 16'd0;
      raw_prev     = 1'b1;
      level_stable = 1'b1;
      halt_tone();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: unused kind, stop while stopped, ignored button, restart
      add_event(KIND_UNUSED, 1'b1);
      add_event(KIND_STOP, 1'b1);
      add_event(KIND_TICK, 1'b0);
      add_event(KIND_TICK, 1'b1);
      add_event(KIND_START, 1'b1);
      add_event(KIND_TICK, 1'b1);
      add_event(KIND_TICK, 1'b1);
      add_event(KIND_START, 1'b0);
      add_event(KIND_TICK, 1'b0);
      add_event(KIND_STOP, 1'b1);
      add_event(KIND_UNUSED, 1'b0);
      wait_drained();

      // wide up sweep clamp, signed down clamp, zero intervals and zero beep count
      c = '{base_hz: 16'd60000, top_hz: 16'hFFFF, sweep_step_hz: 16'hFFFF,
            beep_hz: 16'hFFFF, sweep_step_ms: 16'd0, beep_on_ms: 16'd0,
            beep_off_ms: 16'd0, beeps_per_cycle: 6'd0};
      set_config(c);
      add_event(KIND_START, 1'b1);
      repeat (5) add_event(KIND_TICK, 1'b1);
      wait_drained();

      // base above top, silent beep tone
      c = '{base_hz: 16'd5000, top_hz: 16'd1000, sweep_step_hz: 16'd1,
            beep_hz: 16'd0, sweep_step_ms: 16'd1, beep_on_ms: 16'd0,
            beep_off_ms: 16'd1, beeps_per_cycle: 6'd1};
      set_config(c);
      add_event(KIND_START, 1'b1);
      repeat (6) add_event(KIND_TICK, 1'b1);
      wait_drained();

      for (int run_i = 0; run_i < 8; run_i++) begin
         case (run_i % 4)
            0: begin
               c.base_hz         = 16'($urandom_range(0, 2000));
               c.top_hz          = c.base_hz + 16'($urandom_range(0, 3000));
               c.sweep_step_hz   = 16'($urandom_range(100, 800));
               c.beep_hz         = 16'($urandom);
               c.sweep_step_ms   = 16'($urandom_range(0, 3));
               c.beep_on_ms      = 16'($urandom_range(0, 3));
               c.beep_off_ms     = 16'($urandom_range(0, 3));
               c.beeps_per_cycle = 6'($urandom_range(1, 4));
            end
            1: begin
               c.base_hz         = 16'($urandom);
               c.top_hz          = 16'($urandom);
               c.sweep_step_hz   = 16'($urandom_range(1, 65535));
               c.beep_hz         = 16'($urandom);
               c.sweep_step_ms   = 16'($urandom_range(0, 5));
               c.beep_on_ms      = 16'($urandom_range(0, 5));
               c.beep_off_ms     = 16'($urandom_range(0, 5));
               c.beeps_per_cycle = 6'($urandom_range(0, 63));
            end
            2: begin
               if (run_i < 4) begin
                  c = '{base_hz: 16'd0, top_hz: 16'hFFFF, sweep_step_hz: 16'hFFFF,
                        beep_hz: 16'hFFFF, sweep_step_ms: 16'd0, beep_on_ms: 16'd1,
                        beep_off_ms: 16'd0, beeps_per_cycle: 6'd63};
               end else begin
                  c = '{base_hz: 16'hFFFF, top_hz: 16'd0, sweep_step_hz: 16'd1,
                        beep_hz: 16'd0, sweep_step_ms: 16'hFFFF, beep_on_ms: 16'd0,
                        beep_off_ms: 16'd0, beeps_per_cycle: 6'd1};
               end
            end
            default: begin
               c.base_hz         = 16'($urandom_range(200, 4000));
               c.top_hz          = c.base_hz + 16'($urandom_range(500, 6000));
               c.sweep_step_hz   = 16'((c.top_hz - c.base_hz) / 16'd4) + 16'd1;
               c.beep_hz         = 16'($urandom);
               c.sweep_step_ms   = 16'($urandom_range(2, 10));
               c.beep_on_ms      = 16'($urandom_range(2, 10));
               c.beep_off_ms     = 16'($urandom_range(2, 10));
               c.beeps_per_cycle = 6'($urandom_range(1, 6));
            end
         endcase
         set_config(c);
         calm = (run_i == 3);
         add_event(KIND_START, 1'b1);
         repeat (104) begin
            r = int'($urandom_range(0, 99));
            if (r < 4) kind = KIND_START;
            else if (r < 6) kind = KIND_STOP;
            else if (r < 8) kind = KIND_UNUSED;
            else kind = KIND_TICK;
            if (kind != KIND_TICK) begin
               level = 1'($urandom_range(0, 1));
            end else begin
               // presses are either short glitches or holds past the settle time
               if (press_left > 0) begin
                  level      = 1'b0;
                  press_left = press_left - 1;
               end else begin
                  level = 1'b1;
                  if ($urandom_range(0, 99) < 3)
                     press_left = $urandom_range(0, 1) ? int'($urandom_range(52, 75))
                                                       : int'($urandom_range(1, 12));
               end
               if ($urandom_range(0, 99) < 2) level = !level;
            end
            add_event(kind, level);
         end
         wait_drained();
         calm = 1'b0;
      end

      repeat (4) @(posedge clock);
      if (faults == 0 && status_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/ats_pkg.sv
hdl/ats_csr.sv
hdl/ats_seq.sv
hdl/alarm_tone_sequencer.sv
hdl/ats_checker.sv
bench/alarm_tone_sequencer_test.sv
